// ----- hw/rtl/dbba_pkg.sv -----
// shared types and constants of the disk block bitmap allocator
`default_nettype none

package dbba_pkg;

    localparam int OP_W     = 2;
    localparam int BLOCK_W  = 8;
    localparam int LIMIT_W  = 9;
    localparam int COUNT_W  = 8;
    localparam int WORD_W   = 16;
    localparam int BIT_W    = 4;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

    localparam logic [LIMIT_W-1:0] FIRST_DATA_BLOCK = 9'd2;
    localparam logic [LIMIT_W-1:0] MAX_BLOCK_RESET  = 9'd256;

    // blocks 0 and 1 hold the directory
    localparam logic [WORD_W-1:0] DIR_WORD = 16'h0003;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/dbba_in_if.sv -----
// request channel: operation and block number
`default_nettype none

interface dbba_in_if
    import dbba_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [BLOCK_W-1:0] block;

    modport source (output valid, output operation, output block, input ready);
    modport sink   (input valid, input operation, input block, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dbba_out_if.sv -----
// result channel: allocated block, mark flag and used count
`default_nettype none

interface dbba_out_if
    import dbba_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] allocated_block;
    logic               newly_marked;
    logic [COUNT_W-1:0] used_count;

    modport source (output valid, output allocated_block, output newly_marked,
                    output used_count, input ready);
    modport sink   (input valid, input allocated_block, input newly_marked,
                    input used_count, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dbba_cfg_if.sv -----
// configuration write channel for the allocation limit
`default_nettype none

interface dbba_cfg_if
    import dbba_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] max_block;

    modport source (output valid, output max_block, input ready);
    modport sink   (input valid, input max_block, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dbba_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module dbba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ----- hw/rtl/disk_block_bitmap_allocator.sv -----
// Disk block bitmap allocator, top level.
// One usage bit per block, kept as 16-bit rows in a small ram; a valid bit per
// row stands for the cleared state, so clear takes effect at once.
// Channels: i_in carries operation (clear, mark, allocate) and block, o_out
// returns allocated_block, newly_marked and used_count, one beat per request.
// i_cfg writes max_block, the exclusive allocation limit, and is always ready.
// Sequence: clear, unused codes, ignored marks and allocates under a limit of 2
// or less go from idle straight to the done state, which loads the output register;
// mark passes through read and evaluate first; allocate repeats read and evaluate,
// the scan visiting one 16-block row per read/evaluate pair on the single ram port.
// One request at a time: the next one is accepted the cycle after the result
// is loaded into the output register.
// Reset: map holds blocks 0 and 1 only, count zero, max_block 256.
// A stalled receiver holds the result in the output register; the sequencer
// waits in its final state until the register frees.
`default_nettype none

module disk_block_bitmap_allocator
    import dbba_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dbba_in_if.sink    i_in,
    dbba_out_if.source o_out,
    dbba_cfg_if.sink   i_cfg
);
    localparam int ROWS   = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_AW = ROWS > 1 ? $clog2(ROWS) : 1;

    t_state              r_state, n_state;
    logic [ROW_AW-1:0]   r_row, n_row;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic                r_is_mark, n_is_mark;
    logic [ROWS-1:0]     r_rowvalid, n_rowvalid;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [BLOCK_W-1:0]  r_res_alloc, n_res_alloc;
    logic                r_res_new, n_res_new;
    logic                r_o_valid, n_o_valid;
    logic [BLOCK_W-1:0]  r_o_alloc, n_o_alloc;
    logic                r_o_new, n_o_new;
    logic [COUNT_W-1:0]  r_o_count, n_o_count;
    logic [LIMIT_W-1:0]  r_max;

    logic                ram_we;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    logic [LIMIT_W-1:0]  lim;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   allowed;
    logic [WORD_W-1:0]   free;
    logic [BIT_W-1:0]    hit_idx;
    logic [LIMIT_W-1:0]  row_end;
    logic                last_row;
    logic                in_beat;

    dbba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (ram_wdata),
        .i_raddr (r_row),
        .o_rdata (ram_rdata)
    );

    assign in_beat     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_o_valid;
    assign o_out.allocated_block = r_o_alloc;
    assign o_out.newly_marked    = r_o_new;
    assign o_out.used_count      = r_o_count;

    assign lim = (r_max > LIMIT_W'(NUM_BLOCKS)) ? LIMIT_W'(NUM_BLOCKS) : r_max;

    // row contents, invalid rows read as their cleared value
    always_comb begin
        if (r_rowvalid[r_row]) begin
            word = ram_rdata;
        end else if (r_row == '0) begin
            word = DIR_WORD;
        end else begin
            word = '0;
        end
    end

    always_comb begin
        logic [LIMIT_W-1:0] cand;
        cand = '0;
        for (int j = 0; j < WORD_W; j++) begin
            cand       = LIMIT_W'({r_row, BIT_W'(j)});
            allowed[j] = (cand >= FIRST_DATA_BLOCK) && (cand < lim);
        end
    end

    assign free = ~word & allowed;

    always_comb begin
        hit_idx = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (free[j]) begin
                hit_idx = BIT_W'(j);
            end
        end
    end

    assign row_end  = LIMIT_W'({r_row, {BIT_W{1'b0}}}) + LIMIT_W'(WORD_W);
    assign last_row = (r_row == ROW_AW'(ROWS - 1));

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_bit       = r_bit;
        n_is_mark   = r_is_mark;
        n_rowvalid  = r_rowvalid;
        n_count     = r_count;
        n_res_alloc = r_res_alloc;
        n_res_new   = r_res_new;
        n_o_valid   = r_o_valid;
        n_o_alloc   = r_o_alloc;
        n_o_new     = r_o_new;
        n_o_count   = r_o_count;
        ram_we      = 1'b0;
        ram_wdata   = word;

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_res_alloc = '0;
                    n_res_new   = 1'b0;
                    n_state     = ST_DONE;
                    case (i_in.operation)
                        OP_CLEAR: begin
                            n_rowvalid = '0;
                            n_count    = '0;
                        end
                        OP_MARK: begin
                            if ({1'b0, i_in.block} >= FIRST_DATA_BLOCK &&
                                {1'b0, i_in.block} < LIMIT_W'(NUM_BLOCKS)) begin
                                n_row     = i_in.block[ROW_AW+BIT_W-1:BIT_W];
                                n_bit     = i_in.block[BIT_W-1:0];
                                n_is_mark = 1'b1;
                                n_state   = ST_READ;
                            end
                        end
                        OP_ALLOC: begin
                            if (lim > FIRST_DATA_BLOCK) begin
                                n_row     = '0;
                                n_is_mark = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_is_mark) begin
                    n_state = ST_DONE;
                    if (!word[r_bit]) begin
                        ram_we            = 1'b1;
                        ram_wdata         = word | (WORD_W'(1) << r_bit);
                        n_rowvalid[r_row] = 1'b1;
                        n_count           = r_count + COUNT_W'(1);
                        n_res_new         = 1'b1;
                    end
                end else if (|free) begin
                    ram_we            = 1'b1;
                    ram_wdata         = word | (WORD_W'(1) << hit_idx);
                    n_rowvalid[r_row] = 1'b1;
                    n_res_alloc       = BLOCK_W'({r_row, hit_idx});
                    n_state           = ST_DONE;
                end else if (last_row || row_end >= lim) begin
                    n_state = ST_DONE;
                end else begin
                    n_row   = r_row + ROW_AW'(1);
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o_alloc = r_res_alloc;
                    n_o_new   = r_res_new;
                    n_o_count = r_count;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rowvalid <= '0;
            r_count    <= '0;
            r_o_valid  <= 1'b0;
            r_max      <= MAX_BLOCK_RESET;
        end else begin
            r_state    <= n_state;
            r_rowvalid <= n_rowvalid;
            r_count    <= n_count;
            r_o_valid  <= n_o_valid;
            if (i_cfg.valid) begin
                r_max <= i_cfg.max_block;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_bit       <= n_bit;
        r_is_mark   <= n_is_mark;
        r_res_alloc <= n_res_alloc;
        r_res_new   <= n_res_new;
        r_o_alloc   <= n_o_alloc;
        r_o_new     <= n_o_new;
        r_o_count   <= n_o_count;
    end

`ifndef SYNTHESIS
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in.ready)
        else $error("request accepted while busy");

    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_new) |-> (r_o_count != '0))
        else $error("new mark with zero count");

    a_alloc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_alloc != '0) |-> ({1'b0, r_o_alloc} >= FIRST_DATA_BLOCK))
        else $error("allocated a directory block");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_new && r_o_alloc != '0))
        else $error("result is both mark and allocate");
`endif
endmodule

`default_nettype wire

// ----- dv/dbba_alloc_checker.sv -----
// result checker for the disk block bitmap allocator: shadow map, expected beats, compare
`timescale 1ns / 1ps

module dbba_alloc_checker
    import dbba_pkg::*;
#(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dbba_in_if        i_req,
    dbba_out_if       i_rsp,
    dbba_cfg_if       i_cfg,
    output int        o_errors,
    output int        o_pending
);

    typedef struct packed {
        logic [BLOCK_W-1:0] allocated_block;
        logic               newly_marked;
        logic [COUNT_W-1:0] used_count;
    } t_alloc_result;

    logic [NUM_BLOCKS-1:0] shadow_map;
    logic [COUNT_W-1:0]    shadow_total;
    logic [LIMIT_W-1:0]    shadow_limit;
    t_alloc_result         due_results[$];
    int                    errors  = 0;
    int                    pending = 0;

    assign o_errors  = errors;
    assign o_pending = pending;

    function automatic void wipe_map();
        shadow_map      = '0;
        shadow_map[1:0] = 2'b11;
        shadow_total    = '0;
    endfunction

    function automatic t_alloc_result apply_request(input logic [OP_W-1:0] op,
                                                    input logic [BLOCK_W-1:0] blk);
        t_alloc_result r;
        int            lim;
        logic          found;
        r = '0;
        case (op)
            OP_CLEAR: begin
                wipe_map();
            end
            OP_MARK: begin
                if (blk >= FIRST_DATA_BLOCK && int'(blk) < NUM_BLOCKS && !shadow_map[blk]) begin
                    shadow_map[blk] = 1'b1;
                    shadow_total    = shadow_total + 1'b1;
                    r.newly_marked  = 1'b1;
                end
            end
            OP_ALLOC: begin
                lim   = (int'(shadow_limit) > NUM_BLOCKS) ? NUM_BLOCKS : int'(shadow_limit);
                found = 1'b0;
                for (int i = FIRST_DATA_BLOCK; i < lim && !found; i++) begin
                    if (!shadow_map[i]) begin
                        shadow_map[i]     = 1'b1;
                        r.allocated_block = BLOCK_W'(i);
                        found             = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.used_count = shadow_total;
        return r;
    endfunction

    task automatic log_fault(input string what, input logic have_want,
                             input t_alloc_result want, input t_alloc_result got);
        if (errors < 10) begin
            if (have_want)
                $display("%0t %s: expected alloc %0d new %0b used %0d, got alloc %0d new %0b used %0d",
                         $time, what, want.allocated_block, want.newly_marked, want.used_count,
                         got.allocated_block, got.newly_marked, got.used_count);
            else
                $display("%0t %s: got alloc %0d new %0b used %0d", $time, what,
                         got.allocated_block, got.newly_marked, got.used_count);
        end
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_alloc_result want;
        t_alloc_result got;
        if (!i_rst_n) begin
            wipe_map();
            shadow_limit = MAX_BLOCK_RESET;
            due_results.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.allocated_block, i_rsp.newly_marked, i_rsp.used_count};
                if (due_results.size() == 0) begin
                    log_fault("result beat with none expected", 1'b0, '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want)
                        log_fault("result mismatch", 1'b1, want, got);
                end
            end
            if (i_cfg.valid && i_cfg.ready)
                shadow_limit = i_cfg.max_block;
            if (i_req.valid && i_req.ready)
                due_results.push_back(apply_request(i_req.operation, i_req.block));
        end
        pending = due_results.size();
    end

endmodule

// ----- dv/disk_block_bitmap_allocator_tb.sv -----
// top-level testbench for the disk block bitmap allocator: stimulus, flow control, verdict
`timescale 1ns / 1ps

module disk_block_bitmap_allocator_tb;
    import dbba_pkg::*;

    localparam int NUM_BLOCKS = 256;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 160;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 35;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dbba_in_if  req_if ();
    dbba_out_if rsp_if ();
    dbba_cfg_if cfg_if ();

    int errors;
    int pending;
    int send_gap_pct = 14;
    int recv_gap_pct = 66;
    int hold_reqs    = 0;
    int quiet_cycles = 0;

    disk_block_bitmap_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if),
        .i_cfg   (cfg_if)
    );

    dbba_alloc_checker #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) checker_i (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_if),
        .i_rsp     (rsp_if),
        .i_cfg     (cfg_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic put_request(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] blk);
        while ($urandom_range(99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.block     <= blk;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        drain();
        cfg_if.valid     <= 1'b1;
        cfg_if.max_block <= lim;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int                 fill_order[254];
        int                 j;
        int                 tmp;
        int                 r;
        logic [OP_W-1:0]    op;
        logic [BLOCK_W-1:0] blk;
        logic [LIMIT_W-1:0] lim;

        req_if.valid     = 1'b0;
        req_if.operation = OP_CLEAR;
        req_if.block     = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.max_block = MAX_BLOCK_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset limit, directory blocks, repeats, unused code, clear
        put_request(OP_ALLOC, 8'h00);
        put_request(OP_MARK, 8'h00);
        put_request(OP_MARK, 8'h01);
        put_request(OP_MARK, 8'h02);
        put_request(OP_MARK, 8'hFF);
        put_request(OP_MARK, 8'hFF);
        put_request(OP_MARK, 8'h03);
        put_request(OP_ALLOC, 8'hFF);
        put_request(OP_UNUSED, 8'hFF);
        put_request(OP_UNUSED, 8'h00);
        put_request(OP_CLEAR, 8'hFF);
        put_request(OP_ALLOC, 8'h00);
        // tiny limits: 0 and 2 find nothing, 3 allows block 2 only
        write_limit(9'd0);
        put_request(OP_ALLOC, 8'h00);
        write_limit(9'd2);
        put_request(OP_ALLOC, 8'h00);
        write_limit(9'd3);
        put_request(OP_CLEAR, 8'h00);
        put_request(OP_ALLOC, 8'h00);
        put_request(OP_ALLOC, 8'h00);
        put_request(OP_MARK, 8'h02);
        put_request(OP_MARK, 8'hAA);
        put_request(OP_MARK, 8'h55);
        // limits above the disk size are clamped
        write_limit(9'd511);
        put_request(OP_ALLOC, 8'h00);
        put_request(OP_ALLOC, 8'h00);
        write_limit(9'd257);
        put_request(OP_ALLOC, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 4) begin
                send_gap_pct = 66;
                recv_gap_pct = 14;
            end else if (phase == 8) begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            r = $urandom_range(9);
            if (r < 3)
                lim = 9'd256;
            else if (r == 3)
                lim = ($urandom_range(1) == 0) ? LIMIT_W'($urandom_range(3)) : 9'd511;
            else
                lim = LIMIT_W'($urandom_range(511));
            write_limit(lim);

            if (phase == 5 || phase == 9)
                hold_reqs++;

            // full disk: every data block marked in random order
            if (phase == 10) begin
                write_limit(9'd256);
                put_request(OP_CLEAR, 8'h00);
                for (int i = 0; i < 254; i++)
                    fill_order[i] = i + 2;
                for (int i = 253; i > 0; i--) begin
                    j             = $urandom_range(i);
                    tmp           = fill_order[i];
                    fill_order[i] = fill_order[j];
                    fill_order[j] = tmp;
                end
                for (int i = 0; i < 254; i++)
                    put_request(OP_MARK, BLOCK_W'(fill_order[i]));
                put_request(OP_MARK, BLOCK_W'($urandom_range(255)));
                put_request(OP_ALLOC, 8'h00);
                put_request(OP_UNUSED, 8'h00);
                put_request(OP_CLEAR, 8'h00);
            end

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < 4)
                    op = OP_CLEAR;
                else if (r < 7)
                    op = OP_UNUSED;
                else if (r < 52)
                    op = OP_MARK;
                else
                    op = OP_ALLOC;
                blk = ($urandom_range(3) == 0) ? BLOCK_W'($urandom_range(7))
                                               : BLOCK_W'($urandom_range(255));
                put_request(op, blk);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
